// File: sv/lfps_pkg.sv
// shared types, constants and the control program of the line follower steering block
// no dependencies; used by the interfaces and the top level
package lfps_pkg;

	// tuning limits
	localparam int INTEGRAL_LIMIT = 500;
	localparam int OUTPUT_LIMIT   = 100;
	localparam int STEER_GAIN     = 10;
	localparam int SLEW_STEP      = 5;
	localparam int LOST_LIMIT     = 10;
	localparam int DRIVE_LIMIT    = 100;

	// port widths
	localparam int SENSOR_W   = 4;
	localparam int DRIVE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// sensor codes and raw positions
	localparam logic [SENSOR_W-1:0] CODE_WHITE = 4'hF;
	localparam logic signed [7:0]   POS_WHITE  = 8'sd99;

	// reciprocal constants for exact division of small magnitudes
	localparam logic [19:0] RCP10     = 20'd52429;
	localparam int          RCP10_SH  = 19;
	localparam logic [19:0] RCP100    = 20'd671089;
	localparam int          RCP100_SH = 26;

	// register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP_SMALL    = 3'd0,
		REG_KP_MID      = 3'd1,
		REG_KP_LARGE    = 3'd2,
		REG_KD_SMALL    = 3'd3,
		REG_KD_MID      = 3'd4,
		REG_KD_LARGE    = 3'd5,
		REG_KI_GAIN     = 3'd6,
		REG_BASE_SPEEDS = 3'd7
	} cfg_reg_t;

	// error bands
	typedef enum logic [1:0] {
		BAND_SMALL = 2'd0,
		BAND_MID   = 2'd1,
		BAND_LARGE = 2'd2
	} band_t;

	// shared multiplier operations
	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_P    = 3'd1,
		MUL_I    = 3'd2,
		MUL_D    = 3'd3,
		MUL_T    = 3'd4,
		RCP_10   = 3'd5,
		RCP_100  = 3'd6
	} mul_op_t;

	localparam int PC_W = 4;

	// step numbers of the program
	localparam logic [PC_W-1:0] STEP_SETUP = 4'd0;
	localparam logic [PC_W-1:0] STEP_MUL_P = 4'd1;
	localparam logic [PC_W-1:0] STEP_DIV_P = 4'd2;
	localparam logic [PC_W-1:0] STEP_MUL_I = 4'd3;
	localparam logic [PC_W-1:0] STEP_DIV_I = 4'd4;
	localparam logic [PC_W-1:0] STEP_MUL_D = 4'd5;
	localparam logic [PC_W-1:0] STEP_DIV_D = 4'd6;
	localparam logic [PC_W-1:0] STEP_PID   = 4'd7;
	localparam logic [PC_W-1:0] STEP_MUL_T = 4'd8;
	localparam logic [PC_W-1:0] STEP_DIV_T = 4'd9;
	localparam logic [PC_W-1:0] STEP_EMIT  = 4'd10;

	// one control word
	typedef struct packed {
		logic              setup;
		mul_op_t           mul;
		logic              acc;
		logic              pid;
		logic              emit;
		logic              jmp_lost;
		logic [PC_W-1:0]   target;
	} ctrl_t;

	// control program rom
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		c = '0;
		c.mul = MUL_NONE;
		case (pc)
			STEP_SETUP: begin
				c.setup    = 1'b1;
				c.jmp_lost = 1'b1;
				c.target   = STEP_EMIT;
			end
			STEP_MUL_P: c.mul = MUL_P;
			STEP_DIV_P: c.mul = RCP_10;
			STEP_MUL_I: begin
				c.mul = MUL_I;
				c.acc = 1'b1;
			end
			STEP_DIV_I: c.mul = RCP_100;
			STEP_MUL_D: begin
				c.mul = MUL_D;
				c.acc = 1'b1;
			end
			STEP_DIV_D: c.mul = RCP_10;
			STEP_PID:   c.pid = 1'b1;
			STEP_MUL_T: c.mul = MUL_T;
			STEP_DIV_T: c.mul = RCP_10;
			STEP_EMIT:  c.emit = 1'b1;
			default:    c.emit = 1'b1;
		endcase
		return c;
	endfunction

	// sensor code to track position
	function automatic logic signed [7:0] pos_lut(input logic [SENSOR_W-1:0] code);
		logic signed [7:0] p;
		case (code)
			4'd0:    p = 8'sd100;
			4'd1:    p = 8'sd30;
			4'd2:    p = 8'sd12;
			4'd3:    p = 8'sd20;
			4'd4:    p = -8'sd12;
			4'd5:    p = 8'sd0;
			4'd6:    p = 8'sd0;
			4'd7:    p = 8'sd15;
			4'd8:    p = -8'sd30;
			4'd9:    p = -8'sd20;
			4'd10:   p = -8'sd10;
			4'd11:   p = 8'sd5;
			4'd12:   p = -8'sd20;
			4'd13:   p = -8'sd5;
			4'd14:   p = -8'sd15;
			default: p = POS_WHITE;
		endcase
		return p;
	endfunction

endpackage

// File: sv/lfps_in_if.sv
// sensor channel: valid/ready handshake carrying the four line sensor bits
// depends on lfps_pkg
interface lfps_in_if;
	logic                          valid;
	logic                          ready;
	logic [lfps_pkg::SENSOR_W-1:0] sensor_bits;

	modport source (output valid, output sensor_bits, input ready);
	modport sink   (input valid, input sensor_bits, output ready);
endinterface

// File: sv/lfps_out_if.sv
// result channel: valid/ready handshake carrying wheel drives, steering and status
// depends on lfps_pkg
interface lfps_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [lfps_pkg::DRIVE_W-1:0] left_drive;
	logic signed [lfps_pkg::DRIVE_W-1:0] right_drive;
	logic signed [lfps_pkg::DRIVE_W-1:0] steer_output;
	logic signed [7:0]                   track_position;
	logic                                lost;

	modport source (output valid, output left_drive, output right_drive, output steer_output,
		output track_position, output lost, input ready);
	modport sink   (input valid, input left_drive, input right_drive, input steer_output,
		input track_position, input lost, output ready);
endinterface

// File: sv/line_follow_pid_steering.sv
// gain scheduled pid steering controller for a four sensor line follower
// depends on lfps_pkg, lfps_in_if and lfps_out_if

// One sensor transaction in, one result transaction out. A tick runs through an
// eleven step control program that drives one shared 19x20 multiplier: gain
// products for P, I and D, exact division by 10 or 100 through reciprocal
// multiplies, the PID sum and clamp, the steering product, and a final step that
// forms the wheel targets, applies the slew limit and loads the output register.
// A normal tick runs through every step in order; a tick on which the line is
// lost jumps from the setup step straight to the last step. The multiplier is the
// only arithmetic unit of note and sets the step count. The output register
// lets the next tick start while a result still waits; only the last step
// stalls when the previous result has not been taken. Configuration registers
// are written through cfg_we/cfg_index/cfg_data and must be written while idle.
module line_follow_pid_steering (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lfps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfps_pkg::CFG_DATA_W-1:0]   cfg_data,
	lfps_in_if.sink                           sensor,
	lfps_out_if.source                        result
);

	localparam logic signed [12:0] INT_LIM  = 13'(lfps_pkg::INTEGRAL_LIMIT);
	localparam logic signed [14:0] OUT_LIM  = 15'(lfps_pkg::OUTPUT_LIMIT);
	localparam logic signed [14:0] DRV_LIM  = 15'(lfps_pkg::DRIVE_LIMIT);
	localparam logic signed [8:0]  SLEW     = 9'(lfps_pkg::SLEW_STEP);
	localparam logic [7:0]         LOST_LIM = 8'(lfps_pkg::LOST_LIMIT);
	localparam logic [19:0]        STEER_K  = 20'(lfps_pkg::STEER_GAIN);

	// saturate to +-lim
	function automatic logic signed [7:0] clamp8(input logic signed [14:0] v,
		input logic signed [14:0] lim);
		logic signed [7:0] r;
		if (v > lim) begin
			r = 8'(lim);
		end else if (v < -lim) begin
			r = 8'(-lim);
		end else begin
			r = 8'(v);
		end
		return r;
	endfunction

	// move toward target by at most one slew step
	function automatic logic signed [7:0] slew8(input logic signed [7:0] tgt,
		input logic signed [7:0] now);
		logic signed [8:0] d;
		logic signed [7:0] r;
		d = 9'(tgt) - 9'(now);
		if (d > SLEW) begin
			r = 8'(9'(now) + SLEW);
		end else if (d < -SLEW) begin
			r = 8'(9'(now) - SLEW);
		end else begin
			r = tgt;
		end
		return r;
	endfunction

	// configuration registers
	logic [7:0]                        kp_small_q, kp_mid_q, kp_large_q;
	logic [7:0]                        kd_small_q, kd_mid_q, kd_large_q;
	logic [7:0]                        ki_q;
	logic [lfps_pkg::CFG_DATA_W-1:0]   base_q;

	// sequencer
	logic                              busy_q;
	logic [lfps_pkg::PC_W-1:0]         pc_q;
	lfps_pkg::ctrl_t                   ctrl;
	logic                              go;

	// tick state
	logic [lfps_pkg::SENSOR_W-1:0]     code_q;
	logic                              skip_q;
	logic signed [11:0]                int_q;
	logic signed [6:0]                 eprev_q, e_q;
	logic signed [7:0]                 de_q;
	lfps_pkg::band_t                   band_q;
	logic signed [7:0]                 pid_q, left_q, right_q;
	logic [7:0]                        wc_q;
	logic                              lost_q;

	// multiplier and accumulator datapath
	logic [18:0]                       prod_q;
	logic                              msgn_q;
	logic [12:0]                       rq_q;
	logic                              rsgn_q;
	logic signed [13:0]                acc_q;

	// output register
	logic                              res_valid_q;
	logic signed [7:0]                 res_left_q, res_right_q, res_steer_q, res_pos_q;
	logic                              res_lost_q;

	// combinational values
	logic signed [7:0]                 raw_c;
	logic signed [6:0]                 pos_c, e_c;
	logic [4:0]                        mag_c;
	lfps_pkg::band_t                   band_c;
	logic signed [7:0]                 de_c;
	logic signed [12:0]                isum_c;
	logic signed [11:0]                int_n;
	logic [7:0]                        wc_n;
	logic                              lost_n;
	logic [7:0]                        kp_c, kd_c, base_c;
	logic [18:0]                       mul_a;
	logic [19:0]                       mul_b;
	logic                              mul_sgn;
	logic [38:0]                       mul_full;
	logic signed [13:0]                rq_s;
	logic signed [14:0]                psum_c, base_s, lt_c, rt_c;
	logic signed [7:0]                 pid_n, lt_cl, rt_cl, left_n, right_n;

	assign ctrl         = lfps_pkg::ucode(pc_q);
	assign sensor.ready = !busy_q;
	assign go           = busy_q && ctrl.emit && (!res_valid_q || result.ready);

	// position, error, band and integral for the setup step
	always_comb begin
		raw_c  = lfps_pkg::pos_lut(code_q);
		pos_c  = (raw_c >= lfps_pkg::POS_WHITE) ? 7'sd0 : raw_c[6:0];
		e_c    = -pos_c;
		mag_c  = 5'(e_c[6] ? -e_c : e_c);
		if (mag_c < 5'd5) begin
			band_c = lfps_pkg::BAND_SMALL;
		end else if (mag_c < 5'd15) begin
			band_c = lfps_pkg::BAND_MID;
		end else begin
			band_c = lfps_pkg::BAND_LARGE;
		end
		de_c   = 8'(e_c) - 8'(eprev_q);
		isum_c = 13'(int_q) + 13'(e_c);
		if (band_c == lfps_pkg::BAND_SMALL) begin
			int_n = '0;
		end else if (isum_c > INT_LIM) begin
			int_n = 12'(INT_LIM);
		end else if (isum_c < -INT_LIM) begin
			int_n = 12'(-INT_LIM);
		end else begin
			int_n = 12'(isum_c);
		end
	end

	// white run counter and lost decision
	always_comb begin
		if (code_q == lfps_pkg::CODE_WHITE) begin
			wc_n   = (wc_q == 8'hFF) ? wc_q : wc_q + 8'd1;
			lost_n = wc_n > LOST_LIM;
		end else begin
			wc_n   = '0;
			lost_n = 1'b0;
		end
	end

	// banded gains and base speed
	always_comb begin
		case (band_q)
			lfps_pkg::BAND_SMALL: begin
				kp_c   = kp_small_q;
				kd_c   = kd_small_q;
				base_c = {1'b0, base_q[22:16]};
			end
			lfps_pkg::BAND_MID: begin
				kp_c   = kp_mid_q;
				kd_c   = kd_mid_q;
				base_c = base_q[15:8];
			end
			default: begin
				kp_c   = kp_large_q;
				kd_c   = kd_large_q;
				base_c = base_q[7:0];
			end
		endcase
	end

	// shared multiplier operand select
	always_comb begin
		mul_a   = prod_q;
		mul_b   = '0;
		mul_sgn = msgn_q;
		case (ctrl.mul)
			lfps_pkg::MUL_P: begin
				mul_a   = 19'(e_q[6] ? -e_q : e_q);
				mul_b   = 20'(kp_c);
				mul_sgn = e_q[6];
			end
			lfps_pkg::MUL_I: begin
				mul_a   = 19'(int_q[11] ? -int_q : int_q);
				mul_b   = 20'(ki_q);
				mul_sgn = int_q[11];
			end
			lfps_pkg::MUL_D: begin
				mul_a   = 19'(de_q[7] ? -de_q : de_q);
				mul_b   = 20'(kd_c);
				mul_sgn = de_q[7];
			end
			lfps_pkg::MUL_T: begin
				mul_a   = 19'(pid_q[7] ? -pid_q : pid_q);
				mul_b   = STEER_K;
				mul_sgn = pid_q[7];
			end
			lfps_pkg::RCP_10:  mul_b = lfps_pkg::RCP10;
			lfps_pkg::RCP_100: mul_b = lfps_pkg::RCP100;
			default:           mul_b = '0;
		endcase
		mul_full = 39'(mul_a) * 39'(mul_b);
	end

	// pid sum, wheel targets and slew
	always_comb begin
		rq_s    = rsgn_q ? -$signed({1'b0, rq_q}) : $signed({1'b0, rq_q});
		psum_c  = 15'(acc_q) + 15'(rq_s);
		pid_n   = clamp8(psum_c, OUT_LIM);
		base_s  = $signed({7'b0, base_c});
		lt_c    = base_s - 15'(rq_s);
		rt_c    = base_s + 15'(rq_s);
		lt_cl   = clamp8(lt_c, DRV_LIM);
		rt_cl   = clamp8(rt_c, DRV_LIM);
		left_n  = slew8(lt_cl, left_q);
		right_n = slew8(rt_cl, right_q);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_small_q <= 8'd8;
			kp_mid_q   <= 8'd12;
			kp_large_q <= 8'd18;
			kd_small_q <= 8'd5;
			kd_mid_q   <= 8'd8;
			kd_large_q <= 8'd12;
			ki_q       <= 8'd2;
			base_q     <= 23'd3943710;
		end else if (cfg_we) begin
			case (lfps_pkg::cfg_reg_t'(cfg_index))
				lfps_pkg::REG_KP_SMALL:    kp_small_q <= cfg_data[7:0];
				lfps_pkg::REG_KP_MID:      kp_mid_q   <= cfg_data[7:0];
				lfps_pkg::REG_KP_LARGE:    kp_large_q <= cfg_data[7:0];
				lfps_pkg::REG_KD_SMALL:    kd_small_q <= cfg_data[7:0];
				lfps_pkg::REG_KD_MID:      kd_mid_q   <= cfg_data[7:0];
				lfps_pkg::REG_KD_LARGE:    kd_large_q <= cfg_data[7:0];
				lfps_pkg::REG_KI_GAIN:     ki_q       <= cfg_data[7:0];
				lfps_pkg::REG_BASE_SPEEDS: base_q     <= cfg_data;
				default:                   base_q     <= base_q;
			endcase
		end
	end

	// step counter with conditional jump
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= lfps_pkg::STEP_SETUP;
		end else if (!busy_q) begin
			if (sensor.valid) begin
				busy_q <= 1'b1;
				pc_q   <= lfps_pkg::STEP_SETUP;
			end
		end else if (ctrl.emit) begin
			if (go) begin
				busy_q <= 1'b0;
			end
		end else if (ctrl.jmp_lost && lost_n) begin
			pc_q <= ctrl.target;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

	// sensor capture
	always_ff @(posedge clk) begin
		if (sensor.valid && sensor.ready) begin
			code_q <= sensor.sensor_bits;
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q   <= '0;
			eprev_q <= '0;
			pid_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
			wc_q    <= '0;
			lost_q  <= 1'b0;
			skip_q  <= 1'b0;
		end else if (busy_q) begin
			if (ctrl.setup) begin
				wc_q   <= wc_n;
				lost_q <= lost_n;
				skip_q <= lost_n;
				if (!lost_n) begin
					int_q   <= int_n;
					eprev_q <= e_c;
				end
			end
			if (ctrl.pid) begin
				pid_q <= pid_n;
			end
			if (go && !skip_q) begin
				left_q  <= left_n;
				right_q <= right_n;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (busy_q && ctrl.setup) begin
			e_q    <= e_c;
			de_q   <= de_c;
			band_q <= band_c;
			acc_q  <= '0;
		end
		if (busy_q && ctrl.acc) begin
			acc_q <= acc_q + rq_s;
		end
		case (ctrl.mul)
			lfps_pkg::MUL_P, lfps_pkg::MUL_I, lfps_pkg::MUL_D, lfps_pkg::MUL_T: begin
				prod_q <= mul_full[18:0];
				msgn_q <= mul_sgn;
			end
			lfps_pkg::RCP_10: begin
				rq_q   <= 13'(mul_full >> lfps_pkg::RCP10_SH);
				rsgn_q <= msgn_q;
			end
			lfps_pkg::RCP_100: begin
				rq_q   <= 13'(mul_full >> lfps_pkg::RCP100_SH);
				rsgn_q <= msgn_q;
			end
			default: begin
				prod_q <= prod_q;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (go) begin
			res_left_q  <= skip_q ? left_q : left_n;
			res_right_q <= skip_q ? right_q : right_n;
			res_steer_q <= pid_q;
			res_pos_q   <= raw_c;
			res_lost_q  <= lost_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.left_drive     = res_left_q;
	assign result.right_drive    = res_right_q;
	assign result.steer_output   = res_steer_q;
	assign result.track_position = res_pos_q;
	assign result.lost           = res_lost_q;

	// a new tick always starts at the setup step
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(sensor.valid && sensor.ready) |=> (busy_q && pc_q == lfps_pkg::STEP_SETUP))
		else $error("tick did not start at setup step");

	// the held pid term stays within the output limit
	a_pid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && ctrl.pid) |=> (15'(pid_q) <= OUT_LIM && 15'(pid_q) >= -OUT_LIM))
		else $error("pid term out of range");

	// the left wheel command never jumps by more than one slew step
	a_slew_left: assert property (@(posedge clk) disable iff (!arst_n)
		((9'(left_q) - 9'($past(left_q))) <= SLEW &&
		(9'(left_q) - 9'($past(left_q))) >= -SLEW))
		else $error("left wheel exceeded slew step");

	// a busy tick only ends by emitting a result
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !go) |=> busy_q)
		else $error("tick ended without a result");

endmodule
